FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker modules
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TAC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tac implication check failed");

// next-cycle implication, disabled while reset is high
`define TAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tac next-cycle check failed");

`endif

FILE: rtl/core/tac_pkg.sv
// types and constants of the threshold alarm qualifier
// used by every module of the block; no dependencies
package tac_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ERRCODE  = 3'd1,
    ST_NOTEXACT = 3'd2,
    ST_HIHI     = 3'd3,
    ST_HI       = 3'd4,
    ST_LOLO     = 3'd5,
    ST_LO       = 3'd6
  } alarm_kind_t;

  typedef enum logic [2:0] {
    CFG_ERROR_MASK      = 3'd0,
    CFG_EXACT_VALUE     = 3'd1,
    CFG_HIGH_HIGH_LIMIT = 3'd2,
    CFG_HIGH_LIMIT      = 3'd3,
    CFG_LOW_LOW_LIMIT   = 3'd4,
    CFG_LOW_LIMIT       = 3'd5,
    CFG_RING_LENGTH     = 3'd6,
    CFG_TOLERANCE       = 3'd7
  } cfg_index_t;

  localparam int CFG_DATA_W = 33;
  localparam int COUNT_W    = 16;
  localparam int RUN_W      = 30;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [RUN_W-1:0]   RUN_MAX    = '1;
  localparam logic [RUN_W-1:0]   RING_RESET = 30'd1000000000;

  localparam logic signed [32:0] EXACT_RESET = -33'sd4294967296;
  localparam logic signed [32:0] HIGH_RESET  = 33'sd2147483648;
  localparam logic signed [32:0] LOW_RESET   = -33'sd2147483649;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [31:0]        event_flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         alarm_status;
    logic [COUNT_W-1:0] violation_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        error_mask;
    logic signed [32:0] exact_value;
    logic signed [32:0] high_high_limit;
    logic signed [32:0] high_limit;
    logic signed [32:0] low_low_limit;
    logic signed [32:0] low_limit;
    logic [RUN_W-1:0]   ring_length;
    logic [COUNT_W-1:0] tolerance;
  } cfg_t;

endpackage

FILE: rtl/core/tac_classify.sv
// priority limit checks on one sample: gives the violation kind of the item
// depends on tac_pkg
module tac_classify (
  input  tac_pkg::in_item_t    item,
  input  tac_pkg::cfg_t        cfg,
  output tac_pkg::alarm_kind_t kind
);
  import tac_pkg::*;

  // a 33-bit limit fits the sample range when its top two bits agree
  function automatic logic fits(input logic signed [32:0] v);
    fits = (v[32] == v[31]);
  endfunction

  logic signed [32:0] sample;
  logic flag_hit, exact_hit, hihi_hit, hi_hit, lolo_hit, lo_hit;

  assign sample = {item.sample_value[31], item.sample_value};

  assign flag_hit  = |(item.event_flags & cfg.error_mask);
  assign exact_hit = fits(cfg.exact_value) && (sample != cfg.exact_value);
  assign hihi_hit  = fits(cfg.high_high_limit) && (sample >= cfg.high_high_limit);
  assign hi_hit    = fits(cfg.high_limit) && (sample >= cfg.high_limit);
  assign lolo_hit  = fits(cfg.low_low_limit) && (sample <= cfg.low_low_limit);
  assign lo_hit    = fits(cfg.low_limit) && (sample <= cfg.low_limit);

  always_comb begin
    if (flag_hit) begin
      kind = ST_ERRCODE;
    end else if (exact_hit) begin
      kind = ST_NOTEXACT;
    end else if (hihi_hit) begin
      kind = ST_HIHI;
    end else if (hi_hit) begin
      kind = ST_HI;
    end else if (lolo_hit) begin
      kind = ST_LOLO;
    end else if (lo_hit) begin
      kind = ST_LO;
    end else begin
      kind = ST_OK;
    end
  end

endmodule

FILE: rtl/core/tac_counter.sv
// leaky violation counter and clean-run counter, plus the result of the item
// depends on tac_pkg
module tac_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  tac_pkg::alarm_kind_t          kind,
  input  logic [tac_pkg::RUN_W-1:0]     ring_length,
  input  logic [tac_pkg::COUNT_W-1:0]   tolerance,
  output tac_pkg::out_item_t            result_next
);
  import tac_pkg::*;

  logic [COUNT_W-1:0] violation_count, violation_count_next;
  logic [RUN_W-1:0]   clean_run_count, clean_run_count_next;
  logic [RUN_W-1:0]   run_inc;
  logic [COUNT_W-1:0] count_inc;

  assign run_inc   = (clean_run_count == RUN_MAX) ? clean_run_count
                                                  : clean_run_count + 1'b1;
  assign count_inc = (violation_count == COUNT_MAX) ? violation_count
                                                    : violation_count + 1'b1;

  always_comb begin
    if (kind != ST_OK) begin
      violation_count_next = count_inc;
      clean_run_count_next = '0;
    end else begin
      clean_run_count_next = run_inc;
      // decay starts once the clean run is longer than the ring
      if ((violation_count != '0) && (run_inc > ring_length)) begin
        violation_count_next = violation_count - 1'b1;
      end else begin
        violation_count_next = violation_count;
      end
    end
  end

  always_comb begin
    result_next.violation_total = violation_count_next;
    result_next.alarm_status    = (violation_count_next > tolerance) ? kind : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      violation_count <= '0;
      clean_run_count <= RING_RESET;
    end else if (step) begin
      violation_count <= violation_count_next;
      clean_run_count <= clean_run_count_next;
    end
  end

endmodule

FILE: rtl/core/threshold_alarm_qualifier.sv
// threshold alarm qualifier top level: config registers and the two-register pipeline
// depends on tac_pkg, tac_classify, tac_counter
//
// One sample item is taken per clock cycle while item_ready is high. An item sits in the
// input register while the limit checks and the counter update run, and its result moves
// into the result register once the output can advance. Throughput is one item per cycle
// while results are not stalled, set by the single counter update per item as it moves from
// the input register into the result register; a stalled result holds the pipeline, and the
// input side keeps taking items until both registers fill. Configuration writes take effect
// the next cycle; the user must make them while the block is idle, which it does not enforce.
module threshold_alarm_qualifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  tac_pkg::in_item_t                   item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output tac_pkg::out_item_t                  result,
  input  logic                                cfg_we,
  input  tac_pkg::cfg_index_t                 cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tac_pkg::*;

  cfg_t        cfg;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        advance;
  alarm_kind_t kind;
  out_item_t   result_next;

  // configuration registers; extra bits of wide data are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_mask      <= '0;
      cfg.exact_value     <= EXACT_RESET;
      cfg.high_high_limit <= HIGH_RESET;
      cfg.high_limit      <= HIGH_RESET;
      cfg.low_low_limit   <= LOW_RESET;
      cfg.low_limit       <= LOW_RESET;
      cfg.ring_length     <= RING_RESET;
      cfg.tolerance       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ERROR_MASK:      cfg.error_mask      <= cfg_data[31:0];
        CFG_EXACT_VALUE:     cfg.exact_value     <= cfg_data;
        CFG_HIGH_HIGH_LIMIT: cfg.high_high_limit <= cfg_data;
        CFG_HIGH_LIMIT:      cfg.high_limit      <= cfg_data;
        CFG_LOW_LOW_LIMIT:   cfg.low_low_limit   <= cfg_data;
        CFG_LOW_LIMIT:       cfg.low_limit       <= cfg_data;
        CFG_RING_LENGTH:     cfg.ring_length     <= cfg_data[RUN_W-1:0];
        CFG_TOLERANCE:       cfg.tolerance       <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = !result_valid || result_ready;
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (s1_valid && advance) begin
      result <= result_next;
    end
  end

  tac_classify u_classify (
    .item (s1_item),
    .cfg  (cfg),
    .kind (kind)
  );

  tac_counter u_counter (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_valid && advance),
    .kind        (kind),
    .ring_length (cfg.ring_length),
    .tolerance   (cfg.tolerance),
    .result_next (result_next)
  );

endmodule

FILE: rtl/core/tac_checker.sv
// port-level checks of the threshold alarm qualifier, bound to the top level
// depends on tac_pkg and assert_macros.svh
`include "assert_macros.svh"

module tac_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input tac_pkg::out_item_t  result
);
  import tac_pkg::*;

  logic               out_fire;
  logic               stalled;
  logic               alarm_raised;
  logic               fire_pair;
  logic               count_near;
  logic               prev_fire;
  logic [COUNT_W:0]   total_ext;
  logic [COUNT_W:0]   prev_total;

  assign out_fire     = result_valid && result_ready;
  assign stalled      = result_valid && !result_ready;
  assign alarm_raised = result_valid && (result.alarm_status != ST_OK);
  assign total_ext    = {1'b0, result.violation_total};

  // previous result handshake, cleared while in reset
  always_ff @(posedge clk) begin
    prev_fire  <= out_fire && !rst;
    prev_total <= total_ext;
  end

  assign fire_pair  = out_fire && prev_fire;
  assign count_near = (total_ext == prev_total) || (total_ext == prev_total + 1'b1) ||
                      (total_ext + 1'b1 == prev_total);

  // a stalled result holds
  `TAC_ASSERT_NEXT(a_result_hold, clk, rst, stalled, result_valid && $stable(result))

  // an alarm status needs a count above the tolerance, so never with zero count
  `TAC_ASSERT_IMPL(a_status_needs_count, clk, rst, alarm_raised, result.violation_total != '0)

  // empty result register means the input side is open
  `TAC_ASSERT_IMPL(a_ready_when_empty, clk, rst, !result_valid, item_ready)

  // back to back results move the count by at most one
  `TAC_ASSERT_IMPL(a_count_step, clk, rst, fire_pair, count_near)

endmodule

bind threshold_alarm_qualifier tac_checker u_tac_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: tb/alarm_checker.sv
// scoreboard for the threshold alarm qualifier: watches config writes and both channels,
// predicts each result from its own copy of limits and counters, and compares in order
// depends on tac_pkg
module alarm_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_ready,
  input  tac_pkg::in_item_t              item,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  tac_pkg::out_item_t             result,
  input  logic                           cfg_we,
  input  tac_pkg::cfg_index_t            cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_results
);
  import tac_pkg::*;

  localparam logic signed [32:0] SAMPLE_LO = -33'sd2147483648;
  localparam logic signed [32:0] SAMPLE_HI = 33'sd2147483647;

  logic [31:0]        err_mask;
  logic signed [32:0] exact_val;
  logic signed [32:0] hh_lim;
  logic signed [32:0] hi_lim;
  logic signed [32:0] ll_lim;
  logic signed [32:0] lo_lim;
  logic [RUN_W-1:0]   ring_len;
  logic [COUNT_W-1:0] tol;

  logic [COUNT_W-1:0] viol_count;
  logic [RUN_W-1:0]   clean_run;

  out_item_t expected_alarms [$];
  int        result_idx = 0;
  int        fails = 0;
  int        pending = 0;

  assign fail_count      = fails;
  assign pending_results = pending;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fails++;
  endtask

  // a limit outside the 32-bit sample range never fires
  function automatic bit armed(logic signed [32:0] lim);
    return lim >= SAMPLE_LO && lim <= SAMPLE_HI;
  endfunction

  function automatic out_item_t classify_and_count(in_item_t it);
    logic signed [32:0] s;
    alarm_kind_t        kind;
    out_item_t          res;
    s = {it.sample_value[31], it.sample_value};
    if ((it.event_flags & err_mask) != '0) kind = ST_ERRCODE;
    else if (armed(exact_val) && s != exact_val) kind = ST_NOTEXACT;
    else if (armed(hh_lim) && s >= hh_lim) kind = ST_HIHI;
    else if (armed(hi_lim) && s >= hi_lim) kind = ST_HI;
    else if (armed(ll_lim) && s <= ll_lim) kind = ST_LOLO;
    else if (armed(lo_lim) && s <= lo_lim) kind = ST_LO;
    else kind = ST_OK;

    if (kind != ST_OK) begin
      if (viol_count != COUNT_MAX) viol_count++;
      clean_run = '0;
    end else begin
      if (clean_run != RUN_MAX) clean_run++;
      // decay only once the clean run is longer than the ring
      if (viol_count != '0 && clean_run > ring_len) viol_count--;
    end

    res.alarm_status    = (viol_count > tol) ? kind : ST_OK;
    res.violation_total = viol_count;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      err_mask   = '0;
      exact_val  = EXACT_RESET;
      hh_lim     = HIGH_RESET;
      hi_lim     = HIGH_RESET;
      ll_lim     = LOW_RESET;
      lo_lim     = LOW_RESET;
      ring_len   = RING_RESET;
      tol        = '0;
      viol_count = '0;
      clean_run  = RING_RESET;
      expected_alarms.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ERROR_MASK:      err_mask  = cfg_data[31:0];
          CFG_EXACT_VALUE:     exact_val = cfg_data;
          CFG_HIGH_HIGH_LIMIT: hh_lim    = cfg_data;
          CFG_HIGH_LIMIT:      hi_lim    = cfg_data;
          CFG_LOW_LOW_LIMIT:   ll_lim    = cfg_data;
          CFG_LOW_LIMIT:       lo_lim    = cfg_data;
          CFG_RING_LENGTH:     ring_len  = cfg_data[RUN_W-1:0];
          CFG_TOLERANCE:       tol       = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        expected_alarms.insert(expected_alarms.size(), classify_and_count(item));
      if (result_valid && result_ready) begin
        if (expected_alarms.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item outstanding", result_idx));
        end else begin
          want = expected_alarms.pop_front();
          if (result.alarm_status !== want.alarm_status)
            report_mismatch($sformatf("result %0d: alarm_status %0d, expected %0d",
                                      result_idx, result.alarm_status, want.alarm_status));
          if (result.violation_total !== want.violation_total)
            report_mismatch($sformatf("result %0d: violation_total %0d, expected %0d",
                                      result_idx, result.violation_total,
                                      want.violation_total));
        end
        result_idx++;
      end
    end
    pending = expected_alarms.size();
  end

endmodule

FILE: tb/tb_top.sv
// top of the threshold alarm qualifier testbench: clock, reset, stimulus and verdict
// depends on tac_pkg, threshold_alarm_qualifier and alarm_checker
module tb_top;
  import tac_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  in_item_t              item;
  logic                  result_valid;
  logic                  result_ready;
  out_item_t             result;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_results;

  int          idle_pct;
  int          stall_pct;
  logic [32:0] shadow [8];

  threshold_alarm_qualifier u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  alarm_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver back-pressure
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t make_item(logic [31:0] s, logic [31:0] f);
    in_item_t it;
    it.sample_value = s;
    it.event_flags  = f;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic hold_until_drained(int extra);
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [32:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow[idx] = val;
  endtask

  // limit values at and just past the edges of the sample range and the register
  function automatic logic [32:0] extreme_limit();
    case ($urandom_range(5))
      0:       return 33'h1_0000_0000;
      1:       return 33'h0_ffff_ffff;
      2:       return 33'h1_8000_0000;
      3:       return 33'h0_7fff_ffff;
      4:       return 33'h0_8000_0000;
      default: return 33'h1_7fff_ffff;
    endcase
  endfunction

  // samples cluster around the programmed limits so the compares flip often
  function automatic logic [31:0] pick_sample();
    logic [32:0] base;
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3, 4:    base = shadow[CFG_EXACT_VALUE];
      5:       base = shadow[CFG_HIGH_HIGH_LIMIT];
      6:       base = shadow[CFG_HIGH_LIMIT];
      7:       base = shadow[CFG_LOW_LOW_LIMIT];
      8:       base = shadow[CFG_LOW_LIMIT];
      default: return $urandom_range(3000) - 1500;
    endcase
    return base[31:0] + $urandom_range(4) - 2;
  endfunction

  function automatic in_item_t random_item();
    logic [31:0] f;
    int          sel;
    sel = $urandom_range(9);
    if (sel <= 6) f = '0;
    else if (sel == 7) f = $urandom();
    else if (sel == 8) f = 32'd1 << $urandom_range(31);
    else f = '1;
    return make_item(pick_sample(), f);
  endfunction

  task automatic program_settings();
    int          hi, hh, lo, ll, sel;
    logic [31:0] r;
    logic [32:0] lim [4];
    logic [32:0] val;
    hold_until_drained(3);

    sel = $urandom_range(3);
    if (sel == 0) val = '0;
    else if (sel == 1) val = '1;
    else if (sel == 2) val = {1'b0, $urandom()};
    else val = 33'd1 << $urandom_range(31);
    write_reg(CFG_ERROR_MASK, val);

    // the exact check is left off most of the time, else nearly every item violates
    r = $urandom();
    case ($urandom_range(6))
      0:       val = {2'b10, r[30:0]};
      1:       val = {2'b01, r[30:0]};
      2:       val = 33'h1_0000_0000;
      3:       val = 33'h0_ffff_ffff;
      4:       val = 33'h1_8000_0000 + {2'b00, r[30:0]} + {2'b00, r[30:0]};
      5:       begin
        hi = $urandom_range(3000) - 1500;
        val = {hi[31], hi};
      end
      default: val = extreme_limit();
    endcase
    write_reg(CFG_EXACT_VALUE, val);

    hi = $urandom_range(2000) - 1000;
    hh = hi + $urandom_range(500);
    lo = hi - $urandom_range(2000);
    ll = lo - $urandom_range(500);
    lim[0] = {hh[31], hh};
    lim[1] = {hi[31], hi};
    lim[2] = {ll[31], ll};
    lim[3] = {lo[31], lo};
    for (int k = 0; k < 4; k++)
      if ($urandom_range(5) == 0) lim[k] = extreme_limit();
    write_reg(CFG_HIGH_HIGH_LIMIT, lim[0]);
    write_reg(CFG_HIGH_LIMIT, lim[1]);
    write_reg(CFG_LOW_LOW_LIMIT, lim[2]);
    write_reg(CFG_LOW_LIMIT, lim[3]);

    sel = $urandom_range(7);
    if (sel == 0) val = '0;
    else if (sel <= 4) val = $urandom_range(12, 1);
    else if (sel == 5) val = 33'd1000000000;
    else if (sel == 6) val = 33'h1_ffff_ffff;
    else val = $urandom_range(60, 30);
    write_reg(CFG_RING_LENGTH, val);

    sel = $urandom_range(7);
    if (sel <= 1) val = '0;
    else if (sel <= 5) val = $urandom_range(4, 1);
    else if (sel == 6) val = 33'd65535;
    else val = {17'h1_ffff, 16'd2};
    write_reg(CFG_TOLERANCE, val);
  endtask

  task automatic run_segment(int n_items);
    for (int i = 0; i < n_items; i++) begin
      // sender holds off mid-segment until the pipeline is empty
      if (i == n_items / 2) hold_until_drained(2);
      send_item(random_item());
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ERROR_MASK;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    shadow[CFG_ERROR_MASK]      = '0;
    shadow[CFG_EXACT_VALUE]     = EXACT_RESET;
    shadow[CFG_HIGH_HIGH_LIMIT] = HIGH_RESET;
    shadow[CFG_HIGH_LIMIT]      = HIGH_RESET;
    shadow[CFG_LOW_LOW_LIMIT]   = LOW_RESET;
    shadow[CFG_LOW_LIMIT]       = LOW_RESET;
    shadow[CFG_RING_LENGTH]     = RING_RESET;
    shadow[CFG_TOLERANCE]       = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset settings: every check disabled, flags ignored
    send_item(make_item(32'h8000_0000, 32'hffff_ffff));
    send_item(make_item(32'h7fff_ffff, 32'h0));

    // exact value just above the sample range, mask data with a dropped top bit
    hold_until_drained(3);
    write_reg(CFG_ERROR_MASK, 33'h1_8000_0001);
    write_reg(CFG_EXACT_VALUE, 33'h0_8000_0000);
    write_reg(CFG_HIGH_HIGH_LIMIT, 33'd1000);
    write_reg(CFG_HIGH_LIMIT, 33'd100);
    write_reg(CFG_LOW_LOW_LIMIT, -33'sd1000);
    write_reg(CFG_LOW_LIMIT, -33'sd100);
    write_reg(CFG_RING_LENGTH, 33'd2);
    write_reg(CFG_TOLERANCE, 33'd1);
    send_item(make_item(32'd0, 32'h0000_0001));
    send_item(make_item(32'd5000, 32'h8000_0000));
    send_item(make_item(32'd0, 32'h7fff_fffe));
    send_item(make_item(32'd1000, 32'h0));
    send_item(make_item(32'd999, 32'h0));
    send_item(make_item(32'd100, 32'h0));
    send_item(make_item(32'd99, 32'h0));
    send_item(make_item(-32'sd100, 32'h0));
    send_item(make_item(-32'sd99, 32'h0));
    send_item(make_item(-32'sd1000, 32'h0));
    send_item(make_item(-32'sd1001, 32'h0));
    repeat (4) send_item(make_item(32'd0, 32'h0));

    // exact value and high-high limit both at the bottom of the sample range
    hold_until_drained(3);
    write_reg(CFG_EXACT_VALUE, 33'h1_8000_0000);
    write_reg(CFG_HIGH_HIGH_LIMIT, 33'h1_8000_0000);
    write_reg(CFG_RING_LENGTH, 33'd0);
    write_reg(CFG_TOLERANCE, 33'd0);
    send_item(make_item(32'h8000_0000, 32'h0));
    send_item(make_item(32'd0, 32'h0));

    // limits at the top and bottom edges, neighbors just outside stay off
    hold_until_drained(3);
    write_reg(CFG_EXACT_VALUE, 33'h1_7fff_ffff);
    write_reg(CFG_HIGH_HIGH_LIMIT, 33'h0_8000_0000);
    write_reg(CFG_HIGH_LIMIT, 33'h0_7fff_ffff);
    write_reg(CFG_LOW_LOW_LIMIT, 33'h1_7fff_ffff);
    write_reg(CFG_LOW_LIMIT, 33'h1_8000_0000);
    send_item(make_item(32'h7fff_ffff, 32'h0));
    send_item(make_item(32'h7fff_fffe, 32'h0));
    send_item(make_item(32'h8000_0000, 32'h0));
    send_item(make_item(32'h8000_0001, 32'h0));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (int s = 0; s < 2; s++) begin
        program_settings();
        run_segment(64);
      end
    end

    // drive the violation count well above tolerance, then decay with ring length zero
    idle_pct = 0;
    stall_pct = 0;
    hold_until_drained(3);
    write_reg(CFG_ERROR_MASK, 33'h0_ffff_ffff);
    write_reg(CFG_EXACT_VALUE, 33'h1_0000_0000);
    write_reg(CFG_HIGH_HIGH_LIMIT, 33'h0_ffff_ffff);
    write_reg(CFG_HIGH_LIMIT, 33'h1_0000_0000);
    write_reg(CFG_LOW_LOW_LIMIT, 33'h0_8000_0000);
    write_reg(CFG_LOW_LIMIT, 33'h1_7fff_ffff);
    write_reg(CFG_RING_LENGTH, 33'd0);
    write_reg(CFG_TOLERANCE, 33'd20);
    for (int i = 0; i < 40; i++) send_item(make_item($urandom(), $urandom() | 32'd1));
    idle_pct = 14;
    stall_pct = 14;
    for (int i = 0; i < 40; i++)
      send_item(make_item($urandom(), $urandom_range(1) ? 32'h0 : $urandom() | 32'd1));
    hold_until_drained(3);
    write_reg(CFG_TOLERANCE, 33'd65535);
    for (int i = 0; i < 40; i++)
      send_item(make_item($urandom(), $urandom_range(2) == 0 ? 32'h0 : $urandom() | 32'd1));

    hold_until_drained(10);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
